// ===== design/mbps_pkg.sv =====
// Shared constants and register codes for the masked byte pattern scanner.
package mbps_pkg;

  // Default configuration of the top level
  localparam int unsigned MaxPatternBytesDef = 32;
  localparam int unsigned AddressBitsDef     = 48;

  // Fixed field widths
  localparam int unsigned AddrFieldW = 48;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CareW      = 32;
  localparam int unsigned CfgLenW    = 6;
  localparam int unsigned PatWords   = 4;
  localparam int unsigned WordBytes  = 8;

  // APB register file: 64-bit registers at 8-byte spacing
  localparam int unsigned ApbDataW = 64;
  localparam int unsigned PaddrW   = 6;
  localparam int unsigned RegIdxW  = 3;

  typedef enum logic [RegIdxW-1:0] {
    REG_PAT_WORD_0   = 3'd0,
    REG_PAT_WORD_1   = 3'd1,
    REG_PAT_WORD_2   = 3'd2,
    REG_PAT_WORD_3   = 3'd3,
    REG_CARE_MASK    = 3'd4,
    REG_PAT_LENGTH   = 3'd5,
    REG_FIRST_ONLY   = 3'd6
  } mbps_reg_e;

endpackage

// ===== design/masked_byte_pattern_scanner_top.sv =====
// Masked byte pattern scanner: register file, byte window and match compare.
//
//   Channel  | Handshake              | Payload
//   ---------+------------------------+--------------------------------------------
//   in       | in_valid_i/in_ready_o  | data_byte_i, byte_address_i, region_first_i,
//            |                        | scan_first_i
//   out      | out_valid_o/out_ready_i| match_address_o
//   cfg      | APB psel/penable/...   | paddr (8*index), pwdata/prdata 64 bits
//
// One item per cycle sustained while the output is not stalled. An item is
// caught in the input register, then compared against the window and the
// pattern in a single pass into the result register, which drives the output.
// Reset clears the configuration registers, the fill count, the found flag and
// both valid bits; the window bytes are not reset (they are only compared once
// written in the current region). A stall on the output holds the input stage;
// the input stage keeps accepting while the result register is being drained.
module masked_byte_pattern_scanner_top
  import mbps_pkg::*;
#(
  parameter int unsigned MaxPatternBytes = MaxPatternBytesDef,
  parameter int unsigned AddressBits     = AddressBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input items
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ByteW-1:0]      data_byte_i,
  input  logic [AddrFieldW-1:0] byte_address_i,
  input  logic                  region_first_i,
  input  logic                  scan_first_i,
  // result items
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [AddrFieldW-1:0] match_address_o,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrW-1:0]     paddr,
  input  logic [ApbDataW-1:0]   pwdata,
  output logic [ApbDataW-1:0]   prdata,
  output logic                  pready
);

  localparam int unsigned LenW     = $clog2(MaxPatternBytes + 1);
  localparam int unsigned IdxW     = (MaxPatternBytes > 1) ? $clog2(MaxPatternBytes) : 1;
  localparam int unsigned WinDepth = (MaxPatternBytes > 1) ? MaxPatternBytes - 1 : 1;
  localparam logic [AddrFieldW-1:0] AddrMask =
    (AddressBits >= AddrFieldW) ? {AddrFieldW{1'b1}}
                                : ((AddrFieldW'(1) << AddressBits) - AddrFieldW'(1));

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [MaxPatternBytes-1:0][ByteW-1:0] pat_q;
  logic [CareW-1:0]                      care_q;
  logic [CfgLenW-1:0]                    cfg_len_q;
  logic                                  first_only_q;

  logic        cfg_wr;
  mbps_reg_e   reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = mbps_reg_e'(paddr[PaddrW-1 -: RegIdxW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q        <= '0;
      care_q       <= '0;
      cfg_len_q    <= CfgLenW'(1);
      first_only_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PAT_WORD_0, REG_PAT_WORD_1, REG_PAT_WORD_2, REG_PAT_WORD_3: begin
          for (int b = 0; b < MaxPatternBytes; b++) begin
            if (b / WordBytes == int'(reg_idx)) begin
              pat_q[b] <= pwdata[(b % WordBytes)*ByteW +: ByteW];
            end
          end
        end
        REG_CARE_MASK:  care_q       <= pwdata[CareW-1:0];
        REG_PAT_LENGTH: cfg_len_q    <= pwdata[CfgLenW-1:0];
        REG_FIRST_ONLY: first_only_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_PAT_WORD_0, REG_PAT_WORD_1, REG_PAT_WORD_2, REG_PAT_WORD_3: begin
        for (int b = 0; b < MaxPatternBytes; b++) begin
          if (b / WordBytes == int'(reg_idx)) begin
            prdata[(b % WordBytes)*ByteW +: ByteW] = pat_q[b];
          end
        end
      end
      REG_CARE_MASK:  prdata[CareW-1:0]   = care_q;
      REG_PAT_LENGTH: prdata[CfgLenW-1:0] = cfg_len_q;
      REG_FIRST_ONLY: prdata[0]           = first_only_q;
      default: ;
    endcase
  end

  // Effective length: 0 acts as 1, anything past the window size is clamped
  logic [LenW-1:0] len;
  logic [LenW-1:0] len_m1;

  always_comb begin
    if (cfg_len_q == '0) begin
      len = LenW'(1);
    end else if ({1'b0, cfg_len_q} > (CfgLenW+1)'(MaxPatternBytes)) begin
      len = LenW'(MaxPatternBytes);
    end else begin
      len = LenW'(cfg_len_q);
    end
    len_m1 = len - LenW'(1);
  end

  // Care bits past the register width are wildcards
  logic [MaxPatternBytes-1:0] care_ext;

  always_comb begin
    for (int j = 0; j < MaxPatternBytes; j++) begin
      care_ext[j] = (j < CareW) ? care_q[j % CareW] : 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                  s1_valid_q;
  logic [ByteW-1:0]      s1_byte_q;
  logic [AddrFieldW-1:0] s1_addr_q;
  logic                  s1_region_q;
  logic                  s1_scan_q;
  logic                  s1_fire;
  logic                  in_fire;

  logic                  out_valid_q;
  logic [AddrFieldW-1:0] out_addr_q;

  assign s1_fire    = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_fire;
  assign in_fire    = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q   <= data_byte_i;
      s1_addr_q   <= byte_address_i;
      s1_region_q <= region_first_i;
      s1_scan_q   <= scan_first_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Window state and compare
  // ---------------------------------------------------------------------------
  logic [WinDepth-1:0][ByteW-1:0]        win_q;
  logic [MaxPatternBytes-1:0][ByteW-1:0] view;   // view[i]: byte i places back
  logic [LenW-1:0]                       fill_q, fill_base, fill_d;
  logic                                  found_q, found_base, found_d;
  logic                                  hit, report;
  logic [IdxW-1:0]                       pidx;

  always_comb begin
    view[0] = s1_byte_q;
    for (int i = 1; i < MaxPatternBytes; i++) begin
      view[i] = win_q[i-1];
    end
  end

  always_comb begin
    fill_base  = s1_region_q ? '0 : fill_q;
    fill_d     = (fill_base < LenW'(MaxPatternBytes)) ? fill_base + LenW'(1) : fill_base;
    found_base = s1_scan_q ? 1'b0 : found_q;

    // back position i lines up with pattern byte len-1-i
    hit  = (fill_d >= len);
    pidx = '0;
    for (int i = 0; i < MaxPatternBytes; i++) begin
      pidx = IdxW'(len_m1 - LenW'(i));
      if ((LenW'(i) < len) && care_ext[pidx] && (view[i] != pat_q[pidx])) begin
        hit = 1'b0;
      end
    end

    report  = hit & ~(first_only_q & found_base);
    found_d = found_base | report;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      found_q <= 1'b0;
    end else if (s1_fire) begin
      fill_q  <= fill_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      win_q[0] <= s1_byte_q;
      for (int k = 1; k < WinDepth; k++) begin
        win_q[k] <= win_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic out_valid_d;

  assign out_valid_d = s1_fire ? report : (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && report) begin
      out_addr_q <= (s1_addr_q - AddrFieldW'(len_m1)) & AddrMask;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign match_address_o = out_addr_q;

endmodule
